### hw/rtl/voxel_surface_shell_search_core_macros.svh
// Assertion helpers for the core's modules; only the control module uses them.
// Both sample on aclk and are held off while aresetn is low.
`ifndef VOXEL_SURFACE_SHELL_SEARCH_CORE_MACROS_SVH
`define VOXEL_SURFACE_SHELL_SEARCH_CORE_MACROS_SVH

`define VSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

`define VSS_NEVER(lbl, expr, msg) \
    `VSS_ASSERT(lbl, !(expr), msg)

`endif

### hw/rtl/vss_pkg.sv
package vss_pkg;

    localparam int MAX_DIM       = 64;
    localparam int SEARCH_SHELLS = 8;
    localparam int STORE_BYTES   = 32768;

    localparam int COORD_W  = 6;
    localparam int GRID_W   = 7;
    localparam int ADDR_W   = 15;
    localparam int BYTE_W   = 8;
    localparam int RAD_W    = 3;
    localparam int POS_W    = 8;   // candidate/neighbour coordinate, signed
    localparam int OFF_W    = 4;   // shell offset, signed
    localparam int IDX_W    = 18;  // voxel index inside the grid
    localparam int NB_COUNT = 7;   // centre plus six neighbours
    localparam int NB_CNT_W = 3;
    localparam int SHELL_MAX = SEARCH_SHELLS - 1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [1:0] REG_GRID_X = 2'd0;
    localparam logic [1:0] REG_GRID_Y = 2'd1;
    localparam logic [1:0] REG_GRID_Z = 2'd2;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_SURFACE = 2'd1,
        ST_SHELL   = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef struct packed {
        logic               op;
        logic [ADDR_W-1:0]  load_address;
        logic [BYTE_W-1:0]  load_byte;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] start_z;
    } in_t;

    typedef struct packed {
        logic [COORD_W-1:0] found_x;
        logic [COORD_W-1:0] found_y;
        logic [COORD_W-1:0] found_z;
        status_t            status;
        logic [RAD_W-1:0]   shell_radius;
    } out_t;

    typedef struct packed {
        logic [GRID_W-1:0] gx;
        logic [GRID_W-1:0] gy;
        logic [GRID_W-1:0] gz;
    } grid_t;

    typedef struct packed {
        logic    load;
        logic    start;
        logic    issue;
        logic    capture;
        logic    begin_scan;
        logic    advance;
        logic    push;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic issue_last;
        logic pipe_idle;
        logic first_cand;
        logic centre_solid;
        logic surface;
        logic last_cand;
        logic out_free;
    } stat_t;

endpackage

### hw/rtl/voxel_surface_shell_search_core.sv
// Load beat: written to the occupancy store at its accept edge, one beat per cycle while idle.
// Query: per candidate voxel, seven reads through the single store port, then the index
// multiply, store read and neighbour collection stages, then one evaluation. The result
// waits in the core while the output beat is unread; the next beat is accepted in the
// cycle after the result is pushed to the output. Full scan of shells 1..7: 3374 voxels.
// Reset: grid sizes to 64, store kept.
module voxel_surface_shell_search_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  vss_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output vss_pkg::out_t m_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int GRID_W = vss_pkg::GRID_W;
    localparam logic [GRID_W-1:0] DIM_MAX = GRID_W'(vss_pkg::MAX_DIM);

    logic [GRID_W-1:0] gx_reg, gy_reg, gz_reg;
    logic [1:0]        reg_sel;
    logic              wr_en;
    vss_pkg::grid_t    grid;
    vss_pkg::cmd_t     cmd;
    vss_pkg::stat_t    stat;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gx_reg <= DIM_MAX;
            gy_reg <= DIM_MAX;
            gz_reg <= DIM_MAX;
        end else if (wr_en) begin
            unique case (reg_sel)
                vss_pkg::REG_GRID_X: gx_reg <= pwdata[GRID_W-1:0];
                vss_pkg::REG_GRID_Y: gy_reg <= pwdata[GRID_W-1:0];
                vss_pkg::REG_GRID_Z: gz_reg <= pwdata[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            vss_pkg::REG_GRID_X: prdata = 32'(gx_reg);
            vss_pkg::REG_GRID_Y: prdata = 32'(gy_reg);
            vss_pkg::REG_GRID_Z: prdata = 32'(gz_reg);
            default:             prdata = '0;
        endcase
    end

    // sizes above the supported dimension saturate
    assign grid.gx = (gx_reg > DIM_MAX) ? DIM_MAX : gx_reg;
    assign grid.gy = (gy_reg > DIM_MAX) ? DIM_MAX : gy_reg;
    assign grid.gz = (gz_reg > DIM_MAX) ? DIM_MAX : gz_reg;

    vss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_op    (s_data.op),
        .in_ready (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vss_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_data),
        .grid      (grid),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

### hw/rtl/vss_ctrl.sv
`include "voxel_surface_shell_search_core_macros.svh"

module vss_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic           in_op,
    output logic           in_ready,
    input  vss_pkg::stat_t stat,
    output vss_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_EVAL,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = vss_pkg::ST_EMPTY;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_op == vss_pkg::OP_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.start  = 1'b1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                cmd.issue = 1'b1;
                if (stat.issue_last) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (stat.pipe_idle) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (stat.first_cand) begin
                    priority if (!stat.centre_solid) begin
                        cmd.capture = 1'b1;
                        cmd.code    = vss_pkg::ST_EMPTY;
                        state_next  = S_DONE;
                    end else if (stat.surface) begin
                        cmd.capture = 1'b1;
                        cmd.code    = vss_pkg::ST_SURFACE;
                        state_next  = S_DONE;
                    end else begin
                        cmd.begin_scan = 1'b1;
                        state_next     = S_ISSUE;
                    end
                end else begin
                    priority if (stat.surface) begin
                        cmd.capture = 1'b1;
                        cmd.code    = vss_pkg::ST_SHELL;
                        state_next  = S_DONE;
                    end else if (stat.last_cand) begin
                        cmd.capture = 1'b1;
                        cmd.code    = vss_pkg::ST_NONE;
                        state_next  = S_DONE;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = S_ISSUE;
                    end
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `VSS_ASSERT(a_idle_pipe_empty, (state_reg == S_IDLE) |-> stat.pipe_idle, "lookups left over in idle")
    `VSS_ASSERT(a_eval_after_drain, (state_reg == S_EVAL) |-> stat.pipe_idle, "evaluation before all lookups returned")
    `VSS_ASSERT(a_push_needs_room, cmd.push |-> stat.out_free, "result pushed over an unread beat")
    `VSS_NEVER(a_no_scan_past_end, cmd.advance && stat.last_cand, "scan stepped past the last shell")

endmodule

### hw/rtl/vss_dp.sv
module vss_dp (
    input  logic           aclk,
    input  logic           aresetn,
    input  vss_pkg::in_t   in_data,
    input  vss_pkg::grid_t grid,
    input  vss_pkg::cmd_t  cmd,
    output vss_pkg::stat_t stat,
    output logic           out_valid,
    input  logic           out_ready,
    output vss_pkg::out_t  out_data
);

    localparam int POS_W   = vss_pkg::POS_W;
    localparam int OFF_W   = vss_pkg::OFF_W;
    localparam int COORD_W = vss_pkg::COORD_W;
    localparam int GRID_W  = vss_pkg::GRID_W;
    localparam int IDX_W   = vss_pkg::IDX_W;
    localparam int RAD_W   = vss_pkg::RAD_W;
    localparam int NB_W    = vss_pkg::NB_CNT_W;
    localparam int T_W     = COORD_W + GRID_W;
    localparam int P_W     = T_W + GRID_W;

    localparam logic [NB_W-1:0] NB_CENTRE = NB_W'(0);
    localparam logic [NB_W-1:0] NB_XP     = NB_W'(1);
    localparam logic [NB_W-1:0] NB_XN     = NB_W'(2);
    localparam logic [NB_W-1:0] NB_YP     = NB_W'(3);
    localparam logic [NB_W-1:0] NB_YN     = NB_W'(4);
    localparam logic [NB_W-1:0] NB_ZP     = NB_W'(5);
    localparam logic [NB_W-1:0] NB_ZN     = NB_W'(6);
    localparam logic [RAD_W-1:0] R_LAST   = RAD_W'(vss_pkg::SHELL_MAX);

    logic [vss_pkg::BYTE_W-1:0] mem [vss_pkg::STORE_BYTES];

    // start voxel and scan position
    logic [COORD_W-1:0]      sx_reg, sy_reg, sz_reg;
    logic [RAD_W-1:0]        r_reg, r_next;
    logic signed [OFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [OFF_W-1:0] dx_next, dy_next, dz_next;
    logic [NB_W-1:0]         nb_reg;

    // lookup pipeline
    logic                       v1_reg, v2_reg, v3_reg;
    logic                       inb1_reg, inb2_reg, inb3_reg;
    logic [T_W-1:0]             t1_reg;
    logic [COORD_W-1:0]         x1_reg;
    logic [IDX_W-1:0]           idx2_reg;
    logic [vss_pkg::BYTE_W-1:0] q3_reg;
    logic [2:0]                 bit3_reg;
    logic [vss_pkg::NB_COUNT-1:0] sol_reg;

    vss_pkg::out_t res_reg, out_reg;
    logic          out_valid_reg;

    logic signed [POS_W-1:0] cx, cy, cz, nx, ny, nz;
    logic                    inb, solid3;
    logic [P_W-1:0]          idx_full;
    logic signed [OFF_W-1:0] rs, rns;
    logic [RAD_W-1:0]        r_inc;
    logic                    on_x, on_y;

    assign cx = signed'({2'b00, sx_reg}) + signed'({{(POS_W-OFF_W){dx_reg[OFF_W-1]}}, dx_reg});
    assign cy = signed'({2'b00, sy_reg}) + signed'({{(POS_W-OFF_W){dy_reg[OFF_W-1]}}, dy_reg});
    assign cz = signed'({2'b00, sz_reg}) + signed'({{(POS_W-OFF_W){dz_reg[OFF_W-1]}}, dz_reg});

    always_comb begin
        nx = cx;
        ny = cy;
        nz = cz;
        unique case (nb_reg)
            NB_CENTRE: ;
            NB_XP:     nx = cx + POS_W'(1);
            NB_XN:     nx = cx - POS_W'(1);
            NB_YP:     ny = cy + POS_W'(1);
            NB_YN:     ny = cy - POS_W'(1);
            NB_ZP:     nz = cz + POS_W'(1);
            NB_ZN:     nz = cz - POS_W'(1);
            default:   ;
        endcase
    end

    // out of the grid reads as empty; coordinates never exceed 7 bits
    assign inb = !nx[POS_W-1] && (nx[GRID_W-1:0] < grid.gx)
              && !ny[POS_W-1] && (ny[GRID_W-1:0] < grid.gy)
              && !nz[POS_W-1] && (nz[GRID_W-1:0] < grid.gz);

    assign idx_full = P_W'(t1_reg) * P_W'(grid.gx) + P_W'(x1_reg);
    assign solid3   = inb3_reg && q3_reg[bit3_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        inb1_reg <= inb;
        t1_reg   <= T_W'(nz[COORD_W-1:0]) * T_W'(grid.gy) + T_W'(ny[COORD_W-1:0]);
        x1_reg   <= nx[COORD_W-1:0];
        inb2_reg <= inb1_reg;
        idx2_reg <= idx_full[IDX_W-1:0];
        inb3_reg <= inb2_reg;
        bit3_reg <= idx2_reg[2:0];
        if (v3_reg) begin
            sol_reg <= {solid3, sol_reg[vss_pkg::NB_COUNT-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[in_data.load_address] <= in_data.load_byte;
        end
        q3_reg <= mem[idx2_reg[IDX_W-1:3]];
    end

    // shell walk: z fastest; faces not on the shell are skipped in z
    always_comb begin
        rs      = signed'({1'b0, r_reg});
        r_inc   = r_reg + RAD_W'(1);
        rns     = signed'({1'b0, r_inc});
        on_x    = (dx_reg == rs) || (dx_reg == -rs);
        on_y    = (dy_reg == rs) || (dy_reg == -rs);
        r_next  = r_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        dz_next = dz_reg;
        if (dz_reg != rs) begin
            if ((dz_reg == -rs) && !on_x && !on_y) begin
                dz_next = rs;
            end else begin
                dz_next = dz_reg + OFF_W'(1);
            end
        end else begin
            dz_next = -rs;
            if (dy_reg != rs) begin
                dy_next = dy_reg + OFF_W'(1);
            end else begin
                dy_next = -rs;
                if (dx_reg != rs) begin
                    dx_next = dx_reg + OFF_W'(1);
                end else begin
                    r_next  = r_inc;
                    dx_next = -rns;
                    dy_next = -rns;
                    dz_next = -rns;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nb_reg <= NB_CENTRE;
        end else if (cmd.start || (cmd.issue && nb_reg == NB_ZN)) begin
            nb_reg <= NB_CENTRE;
        end else if (cmd.issue) begin
            nb_reg <= nb_reg + NB_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            sx_reg <= in_data.start_x;
            sy_reg <= in_data.start_y;
            sz_reg <= in_data.start_z;
            r_reg  <= '0;
            dx_reg <= '0;
            dy_reg <= '0;
            dz_reg <= '0;
        end else if (cmd.begin_scan) begin
            r_reg  <= RAD_W'(1);
            dx_reg <= -OFF_W'(1);
            dy_reg <= -OFF_W'(1);
            dz_reg <= -OFF_W'(1);
        end else if (cmd.advance) begin
            r_reg  <= r_next;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            dz_reg <= dz_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_reg.status <= cmd.code;
            if (cmd.code == vss_pkg::ST_SHELL) begin
                res_reg.found_x      <= cx[COORD_W-1:0];
                res_reg.found_y      <= cy[COORD_W-1:0];
                res_reg.found_z      <= cz[COORD_W-1:0];
                res_reg.shell_radius <= r_reg;
            end else begin
                res_reg.found_x      <= sx_reg;
                res_reg.found_y      <= sy_reg;
                res_reg.found_z      <= sz_reg;
                res_reg.shell_radius <= '0;
            end
        end
        if (cmd.push) begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign stat.issue_last   = (nb_reg == NB_ZN);
    assign stat.pipe_idle    = !v1_reg && !v2_reg && !v3_reg;
    assign stat.first_cand   = (r_reg == '0);
    assign stat.centre_solid = sol_reg[0];
    assign stat.surface      = sol_reg[0] && !(&sol_reg[vss_pkg::NB_COUNT-1:1]);
    assign stat.last_cand    = (r_reg == R_LAST) && (dx_reg == rs) && (dy_reg == rs)
                            && (dz_reg == rs);
    assign stat.out_free     = !out_valid_reg || out_ready;

endmodule

### tb/tb_voxel_surface_shell_search_core.sv
`timescale 1ns / 100ps
module tb_voxel_surface_shell_search_core;

    localparam int WATCHDOG_LIMIT  = 200000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 30;
    localparam int SHOWN_MISMATCHES = 10;

    localparam int COORD_W = vss_pkg::COORD_W;
    localparam int RAD_W   = vss_pkg::RAD_W;
    localparam int GRID_W  = vss_pkg::GRID_W;
    localparam int ADDR_W  = vss_pkg::ADDR_W;
    localparam int BYTE_W  = vss_pkg::BYTE_W;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    // How store bytes are filled when a query needs bytes not yet loaded
    typedef enum int {
        FILL_CLEAR,
        FILL_HALF,
        FILL_DENSE,
        FILL_DENSER,
        FILL_SOLIDISH,
        FILL_SOLID
    } fill_t;

    class surface_scoreboard;
        bit [7:0]      occupancy [vss_pkg::STORE_BYTES];
        bit            loaded [vss_pkg::STORE_BYTES];
        int            size_x = vss_pkg::MAX_DIM;
        int            size_y = vss_pkg::MAX_DIM;
        int            size_z = vss_pkg::MAX_DIM;
        vss_pkg::out_t awaited_voxels [$];
        int            mismatches = 0;
        bit            tracing = 0;
        bit            unloaded [int];

        function int clamp_dim(int s);
            return (s > vss_pkg::MAX_DIM) ? vss_pkg::MAX_DIM : s;
        endfunction

        function int voxel_index(int x, int y, int z);
            return (z * clamp_dim(size_y) + y) * clamp_dim(size_x) + x;
        endfunction

        function bit solid(int x, int y, int z);
            int idx;
            int addr;
            if (x < 0 || x >= clamp_dim(size_x) || y < 0 || y >= clamp_dim(size_y) ||
                z < 0 || z >= clamp_dim(size_z))
                return 1'b0;
            idx  = voxel_index(x, y, z);
            addr = idx >> 3;
            if (addr >= vss_pkg::STORE_BYTES)
                return 1'b0;
            if (tracing && !loaded[addr])
                unloaded[addr] = 1'b1;
            return occupancy[addr][idx & 7];
        endfunction

        // all seven lookups are made every time, as the hardware does
        function bit surface(int x, int y, int z);
            bit c, xp, xm, yp, ym, zp, zm;
            c  = solid(x, y, z);
            xp = solid(x + 1, y, z);
            xm = solid(x - 1, y, z);
            yp = solid(x, y + 1, z);
            ym = solid(x, y - 1, z);
            zp = solid(x, y, z + 1);
            zm = solid(x, y, z - 1);
            return c && !(xp && xm && yp && ym && zp && zm);
        endfunction

        function vss_pkg::out_t nearest_surface(vss_pkg::in_t q);
            vss_pkg::out_t res;
            int            sx, sy, sz;
            bit            centre, exposed, hit;
            sx = q.start_x;
            sy = q.start_y;
            sz = q.start_z;
            res.found_x      = q.start_x;
            res.found_y      = q.start_y;
            res.found_z      = q.start_z;
            res.shell_radius = '0;
            centre  = solid(sx, sy, sz);
            exposed = surface(sx, sy, sz);
            if (!centre) begin
                res.status = vss_pkg::ST_EMPTY;
            end else if (exposed) begin
                res.status = vss_pkg::ST_SURFACE;
            end else begin
                res.status = vss_pkg::ST_NONE;
                hit = 1'b0;
                for (int r = 1; r <= vss_pkg::SHELL_MAX && !hit; r++)
                    for (int dx = -r; dx <= r && !hit; dx++)
                        for (int dy = -r; dy <= r && !hit; dy++)
                            for (int dz = -r; dz <= r && !hit; dz++)
                                if ((dx == r || dx == -r || dy == r || dy == -r ||
                                     dz == r || dz == -r) &&
                                    surface(sx + dx, sy + dy, sz + dz)) begin
                                    hit = 1'b1;
                                    res.found_x      = COORD_W'(sx + dx);
                                    res.found_y      = COORD_W'(sy + dy);
                                    res.found_z      = COORD_W'(sz + dz);
                                    res.status       = vss_pkg::ST_SHELL;
                                    res.shell_radius = RAD_W'(r);
                                end
            end
            return res;
        endfunction

        function void note_input(vss_pkg::in_t d);
            if (d.op == vss_pkg::OP_LOAD) begin
                if (d.load_address < vss_pkg::STORE_BYTES) begin
                    occupancy[d.load_address] = d.load_byte;
                    loaded[d.load_address]    = 1'b1;
                end
            end else begin
                awaited_voxels = {awaited_voxels, nearest_surface(d)};
            end
        endfunction

        // dry run of a query: collects the store bytes it would read unloaded
        function int trace_unloaded(vss_pkg::in_t q);
            unloaded.delete();
            tracing = 1'b1;
            void'(nearest_surface(q));
            tracing = 1'b0;
            return unloaded.num();
        endfunction

        function void check_result(vss_pkg::out_t got);
            vss_pkg::out_t want;
            if (awaited_voxels.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("[%0t] result beat with no query pending: (%0d,%0d,%0d) st %0d r %0d",
                             $time, got.found_x, got.found_y, got.found_z, got.status,
                             got.shell_radius);
                return;
            end
            want = awaited_voxels.pop_front();
            if (got.found_x !== want.found_x || got.found_y !== want.found_y ||
                got.found_z !== want.found_z || got.status !== want.status ||
                got.shell_radius !== want.shell_radius) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("[%0t] expected (%0d,%0d,%0d) %s r %0d, got (%0d,%0d,%0d) st %0d r %0d",
                             $time, want.found_x, want.found_y, want.found_z,
                             want.status.name(), want.shell_radius, got.found_x, got.found_y,
                             got.found_z, got.status, got.shell_radius);
            end
        endfunction

        function void set_grid(logic [3:0] addr, logic [GRID_W-1:0] v);
            case (addr[3:2])
                vss_pkg::REG_GRID_X: size_x = v;
                vss_pkg::REG_GRID_Y: size_y = v;
                vss_pkg::REG_GRID_Z: size_z = v;
                default: ;
            endcase
        endfunction
    endclass

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    vss_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    vss_pkg::out_t m_data;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [3:0]    paddr   = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;

    surface_scoreboard sb = new();
    bit calm = 1'b0;
    int sent_items = 0;

    voxel_surface_shell_search_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic vss_pkg::in_t scrambled();
        vss_pkg::in_t item;
        item.op           = 1'($urandom_range(0, 1));
        item.load_address = ADDR_W'($urandom);
        item.load_byte    = BYTE_W'($urandom);
        item.start_x      = COORD_W'($urandom);
        item.start_y      = COORD_W'($urandom);
        item.start_z      = COORD_W'($urandom);
        return item;
    endfunction

    function automatic logic [7:0] fill_byte(fill_t f);
        logic [7:0] b;
        int         odds;
        case (f)
            FILL_CLEAR:  return 8'h00;
            FILL_HALF:   return BYTE_W'($urandom);
            FILL_SOLID:  return 8'hFF;
            FILL_DENSE:  odds = 8;
            FILL_DENSER: odds = 32;
            default:     odds = 128;
        endcase
        for (int k = 0; k < 8; k++)
            b[k] = ($urandom_range(0, odds - 1) != 0);
        return b;
    endfunction

    task automatic send_item(vss_pkg::in_t item);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(item);
        sent_items++;
    endtask

    task automatic send_load(int addr, logic [7:0] value);
        vss_pkg::in_t item;
        item              = scrambled();
        item.op           = vss_pkg::OP_LOAD;
        item.load_address = ADDR_W'(addr);
        item.load_byte    = value;
        send_item(item);
    endtask

    // loads whatever the search would read unloaded, then issues the query
    task automatic prepare_and_query(int x, int y, int z, fill_t f);
        vss_pkg::in_t q;
        int           addrs [$];
        q         = scrambled();
        q.op      = vss_pkg::OP_SEARCH;
        q.start_x = COORD_W'(x);
        q.start_y = COORD_W'(y);
        q.start_z = COORD_W'(z);
        while (sb.trace_unloaded(q) != 0) begin
            addrs.delete();
            foreach (sb.unloaded[a])
                addrs = {addrs, a};
            foreach (addrs[i])
                send_load(addrs[i], fill_byte(f));
        end
        send_item(q);
    endtask

    task automatic paint_box(int x0, int x1, int y0, int y1, int z0, int z1, bit fill);
        logic [7:0] image [int];
        int         idx;
        int         addr;
        for (int z = z0; z <= z1; z++)
            for (int y = y0; y <= y1; y++)
                for (int x = x0; x <= x1; x++) begin
                    idx  = sb.voxel_index(x, y, z);
                    addr = idx >> 3;
                    if (!image.exists(addr))
                        image[addr] = sb.occupancy[addr];
                    image[addr][idx & 7] = fill;
                end
        foreach (image[a])
            send_load(a, image[a]);
    endtask

    task automatic write_reg(logic [1:0] index, logic [GRID_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {25'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_grid({index, 2'b00}, v);
    endtask

    // idle the input and let the core finish before touching registers
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.awaited_voxels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_item(bit allow_solid);
        int    gx, gy, gz, span, x, y, z, w;
        fill_t f;
        gx = sb.clamp_dim(sb.size_x);
        gy = sb.clamp_dim(sb.size_y);
        gz = sb.clamp_dim(sb.size_z);
        if ($urandom_range(0, 99) < 30) begin
            span = (gx * gy * gz + 7) / 8;
            w    = $urandom_range(0, 2);
            if (span > 0 && $urandom_range(0, 1))
                send_load($urandom_range(0, span - 1),
                          (w == 0) ? 8'hFF : (w == 1) ? 8'h00 : BYTE_W'($urandom));
            else
                send_load($urandom_range(0, vss_pkg::STORE_BYTES - 1), BYTE_W'($urandom));
        end else begin
            if (gx * gy * gz == 0 || $urandom_range(0, 6) == 0) begin
                x = $urandom_range(0, 63);
                y = $urandom_range(0, 63);
                z = $urandom_range(0, 63);
            end else begin
                x = $urandom_range(0, gx - 1);
                y = $urandom_range(0, gy - 1);
                z = $urandom_range(0, gz - 1);
            end
            w = $urandom_range(0, 99);
            if (w < 10)
                f = FILL_CLEAR;
            else if (w < 35)
                f = FILL_HALF;
            else if (w < 60)
                f = FILL_DENSE;
            else if (w < 80)
                f = FILL_DENSER;
            else if (w < 96 || !allow_solid)
                f = FILL_SOLIDISH;
            else
                f = FILL_SOLID;
            prepare_and_query(x, y, z, f);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    initial begin : result_sink
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("voxel_surface_shell_search_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        int gx, gy, gz, kind, axis, phase_end;
        bit allow_solid;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, on the 64^3 grid left by reset
        send_load(0, 8'hFF);
        send_load(vss_pkg::STORE_BYTES - 1, 8'h80);
        prepare_and_query(0, 0, 0, FILL_SOLID);
        prepare_and_query(63, 63, 63, FILL_SOLID);
        prepare_and_query(30, 5, 40, FILL_CLEAR);
        prepare_and_query(5, 5, 5, FILL_HALF);
        // buried start: nothing exposed within seven shells
        paint_box(12, 28, 12, 28, 12, 28, 1'b1);
        prepare_and_query(20, 20, 20, FILL_SOLID);
        paint_box(24, 24, 20, 20, 20, 20, 1'b0);
        prepare_and_query(20, 20, 20, FILL_SOLID);
        paint_box(24, 24, 20, 20, 20, 20, 1'b1);
        // hole just past the last shell
        paint_box(20, 20, 28, 28, 20, 20, 1'b0);
        prepare_and_query(20, 20, 20, FILL_SOLID);
        paint_box(20, 20, 28, 28, 20, 20, 1'b1);
        // two hits on shell one: scan order decides
        paint_box(22, 22, 20, 20, 20, 20, 1'b0);
        paint_box(18, 18, 20, 20, 20, 20, 1'b0);
        prepare_and_query(20, 20, 20, FILL_SOLID);
        prepare_and_query(18, 20, 20, FILL_SOLID);
        prepare_and_query(63, 0, 63, FILL_DENSE);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            kind = (p < 3) ? p + 7 : $urandom_range(0, 9);
            case (kind)
                5: begin
                    gx   = $urandom_range(1, 3);
                    gy   = $urandom_range(1, 3);
                    gz   = $urandom_range(1, 3);
                    axis = $urandom_range(0, 2);
                    if (axis == 0) gx = $urandom_range(64, 127);
                    else if (axis == 1) gy = $urandom_range(64, 127);
                    else gz = $urandom_range(64, 127);
                end
                6: begin
                    gx   = $urandom_range(1, 64);
                    gy   = $urandom_range(1, 64);
                    gz   = $urandom_range(1, 64);
                    axis = $urandom_range(0, 2);
                    if (axis == 0) gx = 0;
                    else if (axis == 1) gy = 0;
                    else gz = 0;
                end
                7: begin
                    gx = $urandom_range(17, 22);
                    gy = $urandom_range(17, 22);
                    gz = $urandom_range(17, 22);
                end
                8: begin
                    gx = $urandom_range(48, 127);
                    gy = $urandom_range(48, 127);
                    gz = $urandom_range(48, 127);
                end
                9: begin
                    gx = $urandom_range(0, 1) ? 1 : 64;
                    gy = $urandom_range(0, 1) ? 1 : 64;
                    gz = $urandom_range(0, 1) ? 1 : 64;
                end
                default: begin
                    gx = $urandom_range(1, 12);
                    gy = $urandom_range(1, 12);
                    gz = $urandom_range(1, 12);
                end
            endcase
            write_reg(vss_pkg::REG_GRID_X, GRID_W'(gx));
            write_reg(vss_pkg::REG_GRID_Y, GRID_W'(gy));
            write_reg(vss_pkg::REG_GRID_Z, GRID_W'(gz));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, GRID_W'($urandom));
            calm = ($urandom_range(0, 3) == 0);
            // a fully solid fill in a big grid would bury starts and scan for ages
            allow_solid = (kind == 7) || sb.clamp_dim(gx) < 17 || sb.clamp_dim(gy) < 17 ||
                          sb.clamp_dim(gz) < 17;
            // preparatory loads count towards the phase's share of beats
            phase_end = sent_items + ITEMS_PER_PHASE;
            while (sent_items < phase_end)
                random_item(allow_solid);
        end
        settle();

        if (sb.mismatches == 0)
            $display("voxel_surface_shell_search_core regression: pass");
        else
            $display("voxel_surface_shell_search_core regression: fail");
        $finish;
    end

endmodule
